>>> design/mird_pkg.sv
`timescale 1ns / 1ps

package mird_pkg;

    localparam int DUR_W       = 16;
    localparam int HALF_W      = 15;
    localparam int TOL_W       = 16;
    localparam int NBITS_W     = 6;
    localparam int DATA_W      = 32;
    localparam int USED_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int MAX_BITS_DEF    = 32;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam logic [HALF_W-1:0]  HALF_BIT_TIME_RST   = 15'd889;
    localparam logic [TOL_W-1:0]   MATCH_TOLERANCE_RST = 16'd200;
    localparam logic               MARK_IS_ZERO_RST    = 1'b1;
    localparam logic               HIGH_BIT_LEAD_RST   = 1'b1;
    localparam logic [NBITS_W-1:0] FRAME_BITS_RST      = 6'd14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_BIT_TIME   = 3'd0,
        CFG_MATCH_TOLERANCE = 3'd1,
        CFG_MARK_IS_ZERO    = 3'd2,
        CFG_HIGH_BIT_LEAD   = 3'd3,
        CFG_FRAME_BITS      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAILED  = 2'd2
    } frame_status_t;

    typedef enum logic [1:0] {
        SEG_HALF = 2'd0,
        SEG_FULL = 2'd1,
        SEG_BAD  = 2'd2
    } seg_class_t;

    typedef struct packed {
        logic [HALF_W-1:0]  half_bit_time;
        logic [TOL_W-1:0]   match_tolerance;
        logic               mark_is_zero;
        logic               high_bit_lead;
        logic [NBITS_W-1:0] frame_bits;
    } cfg_t;

    typedef struct packed {
        logic [DUR_W-1:0] first_duration;
        logic [DUR_W-1:0] second_duration;
        logic             start_level;
        logic             first_item;
        logic             last_item;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] decoded_data;
        logic              frame_ok;
        logic [USED_W-1:0] items_used;
    } result_t;

    // A segment is one half-bit run, or a full-bit run (two halves); a half match is
    // tried first, and a duration that matches neither within the tolerance is bad.
    function automatic seg_class_t classify_seg(input logic [DUR_W-1:0] d,
                                                input logic [HALF_W-1:0] h,
                                                input logic [TOL_W-1:0] tol);
        logic [DUR_W:0] dx;
        logic [DUR_W:0] hx;
        logic [DUR_W:0] fx;
        logic [DUR_W:0] dh;
        logic [DUR_W:0] df;
        logic [DUR_W:0] tx;
        dx = {1'b0, d};
        hx = {2'b00, h};
        fx = {1'b0, h, 1'b0};
        tx = {1'b0, tol};
        dh = (dx >= hx) ? (dx - hx) : (hx - dx);
        df = (dx >= fx) ? (dx - fx) : (fx - dx);
        if (dh <= tx)
        begin
            return SEG_HALF;
        end
        else if (df <= tx)
        begin
            return SEG_FULL;
        end
        return SEG_BAD;
    endfunction

endpackage

>>> design/mird_cfg_regs.sv
`timescale 1ns / 1ps

module mird_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [mird_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mird_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mird_pkg::cfg_t                       cfg
);

    mird_pkg::cfg_t cfg_reg;
    mird_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (mird_pkg::cfg_index_t'(cfg_index))
                mird_pkg::CFG_HALF_BIT_TIME:
                    cfg_next.half_bit_time = cfg_data[mird_pkg::HALF_W-1:0];
                mird_pkg::CFG_MATCH_TOLERANCE:
                    cfg_next.match_tolerance = cfg_data[mird_pkg::TOL_W-1:0];
                mird_pkg::CFG_MARK_IS_ZERO:
                    cfg_next.mark_is_zero = cfg_data[0];
                mird_pkg::CFG_HIGH_BIT_LEAD:
                    cfg_next.high_bit_lead = cfg_data[0];
                mird_pkg::CFG_FRAME_BITS:
                    cfg_next.frame_bits = cfg_data[mird_pkg::NBITS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_time   <= mird_pkg::HALF_BIT_TIME_RST;
            cfg_reg.match_tolerance <= mird_pkg::MATCH_TOLERANCE_RST;
            cfg_reg.mark_is_zero    <= mird_pkg::MARK_IS_ZERO_RST;
            cfg_reg.high_bit_lead   <= mird_pkg::HIGH_BIT_LEAD_RST;
            cfg_reg.frame_bits      <= mird_pkg::FRAME_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/mird_frame_core.sv
`timescale 1ns / 1ps

module mird_frame_core #(
    parameter int MAX_BITS    = mird_pkg::MAX_BITS_DEF,
    parameter int COUNT_WIDTH = mird_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mird_pkg::cfg_t    cfg,
    input  mird_pkg::item_t   item,
    input  logic              step,
    output mird_pkg::result_t result
);

    localparam int NW = mird_pkg::NBITS_W;

    typedef struct packed {
        logic [MAX_BITS-1:0]    acc;
        logic [NW-1:0]          bits_done;
        logic                   line_level;
        logic                   in_second_half;
        logic                   first_half_level;
        logic [COUNT_WIDTH-1:0] item_count;
        mird_pkg::frame_status_t status;
    } fstate_t;

    fstate_t fs_reg;
    fstate_t fs_next;

    function automatic fstate_t clear_state();
        fstate_t s;
        s.acc              = '0;
        s.bits_done        = '0;
        s.line_level       = 1'b0;
        s.in_second_half   = 1'b0;
        s.first_half_level = 1'b0;
        s.item_count       = '0;
        s.status           = mird_pkg::ST_RUNNING;
        return s;
    endfunction

    function automatic fstate_t store_bit(input fstate_t si, input logic [NW-1:0] n,
                                          input logic rc5, input logic msb);
        fstate_t       s;
        logic          v;
        logic [NW-1:0] pos;
        s   = si;
        v   = rc5 ? ~s.first_half_level : s.first_half_level;
        pos = msb ? (n - NW'(1) - s.bits_done) : s.bits_done;
        if (n != '0 && s.bits_done < n)
        begin
            s.acc       = s.acc | (MAX_BITS'(v) << pos);
            s.bits_done = s.bits_done + NW'(1);
            if (s.bits_done == n)
            begin
                s.status = mird_pkg::ST_DONE;
            end
        end
        return s;
    endfunction

    function automatic fstate_t half_step(input fstate_t si, input logic lvl,
                                          input logic [NW-1:0] n,
                                          input logic rc5, input logic msb);
        fstate_t s;
        s = si;
        if (s.in_second_half)
        begin
            s = store_bit(s, n, rc5, msb);
        end
        else
        begin
            s.first_half_level = lvl;
        end
        s.in_second_half = ~s.in_second_half;
        return s;
    endfunction

    function automatic fstate_t feed(input fstate_t si, input mird_pkg::seg_class_t cls,
                                     input logic lvl, input logic [NW-1:0] n,
                                     input logic rc5, input logic msb);
        fstate_t s;
        s = si;
        if (s.status == mird_pkg::ST_RUNNING)
        begin
            s.line_level = lvl;
            if (cls == mird_pkg::SEG_BAD)
            begin
                s.status = mird_pkg::ST_FAILED;
            end
            else
            begin
                s = half_step(s, lvl, n, rc5, msb);
                // a full-bit run stops early if its first half closed the frame
                if (cls == mird_pkg::SEG_FULL && s.status == mird_pkg::ST_RUNNING)
                begin
                    s = half_step(s, lvl, n, rc5, msb);
                end
            end
        end
        return s;
    endfunction

    logic [NW-1:0]        n_wanted;
    mird_pkg::seg_class_t cls0;
    mird_pkg::seg_class_t cls1;
    logic [15:0]          count_ext;
    logic                 ok;

    assign n_wanted = (cfg.frame_bits > NW'(MAX_BITS)) ? NW'(MAX_BITS) : cfg.frame_bits;
    assign cls0 = mird_pkg::classify_seg(item.first_duration, cfg.half_bit_time,
                                         cfg.match_tolerance);
    assign cls1 = mird_pkg::classify_seg(item.second_duration, cfg.half_bit_time,
                                         cfg.match_tolerance);

    always_comb
    begin
        fstate_t s;
        logic    lvl0;
        s = fs_reg;
        if (item.first_item)
        begin
            s = clear_state();
            if (n_wanted == '0)
            begin
                s.status = mird_pkg::ST_FAILED;
            end
        end
        lvl0 = item.first_item ? item.start_level : ~s.line_level;
        s = feed(s, cls0, lvl0, n_wanted, cfg.mark_is_zero, cfg.high_bit_lead);
        if (s.status == mird_pkg::ST_RUNNING)
        begin
            // zero second segment on the last item means the segment is absent
            if (item.second_duration != '0 || !item.last_item)
            begin
                s = feed(s, cls1, ~s.line_level, n_wanted, cfg.mark_is_zero,
                         cfg.high_bit_lead);
            end
            if (s.item_count != '1)
            begin
                s.item_count = s.item_count + COUNT_WIDTH'(1);
            end
        end
        // trailing half of the final bit may be missing from the capture
        if (item.last_item && s.status == mird_pkg::ST_RUNNING && s.in_second_half &&
            ({1'b0, s.bits_done} + (NW + 1)'(1)) == {1'b0, n_wanted})
        begin
            s = store_bit(s, n_wanted, cfg.mark_is_zero, cfg.high_bit_lead);
        end
        ok        = (s.status == mird_pkg::ST_DONE);
        count_ext = 16'(s.item_count);
        result.frame_ok     = ok;
        result.decoded_data = ok ? mird_pkg::DATA_W'(s.acc) : '0;
        result.items_used   = !ok ? '0 :
                              (count_ext > 16'd255) ? 8'hFF : count_ext[7:0];
        if (item.last_item)
        begin
            s.status = mird_pkg::ST_FAILED;
        end
        fs_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= clear_state();
        end
        else if (step)
        begin
            fs_reg <= fs_next;
        end
    end

endmodule

>>> design/manchester_ir_decoder_top.sv
`timescale 1ns / 1ps

// Manchester IR frame decoder, RC5/RC6 bit polarity.
// Input channel (in_valid/in_ready) carries one captured pulse item per
// transaction: two segment durations, the start level, and first/last marks.
// Output channel (out_valid/out_ready) gives one result per item marked
// last_item: decoded_data, frame_ok and items_used. Other items give none.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no item is in flight.
// Throughput: one item per cycle while no last_item waits on a stalled result.
// Each item is classified and applied to the frame state combinationally
// between the input register and the result register.
// Reset loads the default configuration (889-tick half bit, tolerance 200,
// RC5, MSB first, 14 bits) and opens a frame at line level 0.
// When the receiver stalls, the result register holds; items without a
// result keep flowing, and a last_item that arrives while a result waits is
// held in the input register, which then drops in_ready.
module manchester_ir_decoder_top #(
    parameter int MAX_BITS    = mird_pkg::MAX_BITS_DEF,
    parameter int COUNT_WIDTH = mird_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mird_pkg::DUR_W-1:0]           first_duration,
    input  logic [mird_pkg::DUR_W-1:0]           second_duration,
    input  logic                                 start_level,
    input  logic                                 first_item,
    input  logic                                 last_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mird_pkg::DATA_W-1:0]          decoded_data,
    output logic                                 frame_ok,
    output logic [mird_pkg::USED_W-1:0]          items_used,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mird_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mird_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mird_pkg::cfg_t    cfg;
    mird_pkg::item_t   in_reg;
    logic              in_vld_reg;
    mird_pkg::result_t res;
    mird_pkg::result_t out_reg;
    logic              out_vld_reg;
    logic              advance;

    assign cfg_ready = 1'b1;

    mird_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // an item with no result never waits on the output side
    assign advance  = in_vld_reg && (!in_reg.last_item || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg.first_duration  <= first_duration;
            in_reg.second_duration <= second_duration;
            in_reg.start_level     <= start_level;
            in_reg.first_item      <= first_item;
            in_reg.last_item       <= last_item;
        end
    end

    mird_frame_core #(
        .MAX_BITS    (MAX_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_reg),
        .step   (advance),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_reg.last_item)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_reg.last_item)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign decoded_data = out_reg.decoded_data;
    assign frame_ok     = out_reg.frame_ok;
    assign items_used   = out_reg.items_used;

endmodule

>>> dv/mird_frame_checker.sv
`timescale 1ns / 1ps

module mird_frame_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [mird_pkg::DUR_W-1:0]       first_duration,
    input  logic [mird_pkg::DUR_W-1:0]       second_duration,
    input  logic                             start_level,
    input  logic                             first_item,
    input  logic                             last_item,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [mird_pkg::DATA_W-1:0]      decoded_data,
    input  logic                             frame_ok,
    input  logic [mird_pkg::USED_W-1:0]      items_used,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [mird_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mird_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending
);

    localparam int unsigned COUNT_MAX = (1 << mird_pkg::COUNT_WIDTH_DEF) - 1;

    // register copies
    logic [mird_pkg::HALF_W-1:0]  half_q;
    logic [mird_pkg::TOL_W-1:0]   tol_q;
    logic                         zero_mark_q;
    logic                         lead_q;
    logic [mird_pkg::NBITS_W-1:0] nbits_q;

    // frame decode state
    logic [mird_pkg::DATA_W-1:0] acc;
    int unsigned                 done_cnt;
    int unsigned                 rem;
    logic                        level;
    logic                        second_half;
    logic                        head_level;
    int unsigned                 used_cnt;
    mird_pkg::frame_status_t     status;

    mird_pkg::result_t frame_reports_q[$];

    function automatic int unsigned bits_wanted();
        int unsigned n;
        n = nbits_q;
        return (n > mird_pkg::MAX_BITS_DEF) ? mird_pkg::MAX_BITS_DEF : n;
    endfunction

    function automatic bit near_nominal(input int unsigned d, input int unsigned nom);
        int unsigned diff;
        diff = (d >= nom) ? d - nom : nom - d;
        return diff <= tol_q;
    endfunction

    function automatic void frame_clear();
        acc         = '0;
        done_cnt    = 0;
        rem         = 0;
        level       = 1'b0;
        second_half = 1'b0;
        head_level  = 1'b0;
        used_cnt    = 0;
        status      = mird_pkg::ST_RUNNING;
    endfunction

    function automatic void store_bit();
        int unsigned n;
        int unsigned pos;
        logic        v;
        n = bits_wanted();
        v = zero_mark_q ? ~head_level : head_level;
        if (n == 0 || done_cnt >= n)
            return;
        pos = lead_q ? (n - 1 - done_cnt) : done_cnt;
        acc = acc | (32'(v) << pos[4:0]);
        done_cnt++;
        if (done_cnt == n)
            status = mird_pkg::ST_DONE;
    endfunction

    // one half-bit decision; a full-bit run leaves a half behind for the next call
    function automatic void half_step();
        int unsigned h;
        int unsigned r;
        h = half_q;
        r = rem;
        if (!second_half)
            head_level = level;
        if (near_nominal(r, h))
            r = 0;
        else if (near_nominal(r, 2 * h))
            r = (r > h) ? r - h : 0;
        else
        begin
            status = mird_pkg::ST_FAILED;
            rem    = 0;
            return;
        end
        rem = r;
        if (second_half)
            store_bit();
        second_half = ~second_half;
    endfunction

    function automatic void feed_segment(input int unsigned d, input bit opening,
                                         input logic start);
        if (status != mird_pkg::ST_RUNNING)
            return;
        level = opening ? start : ~level;
        rem   = d;
        do
            half_step();
        while (status == mird_pkg::ST_RUNNING && rem > 0);
    endfunction

    function automatic bit decode_item(input logic [mird_pkg::DUR_W-1:0] d0,
                                       input logic [mird_pkg::DUR_W-1:0] d1,
                                       input logic sl, input logic fi, input logic li,
                                       output mird_pkg::result_t rep);
        bit ok;
        rep = '0;
        if (fi)
        begin
            frame_clear();
            if (bits_wanted() == 0)
                status = mird_pkg::ST_FAILED;
        end
        feed_segment(d0, fi, sl);
        if (status == mird_pkg::ST_RUNNING)
        begin
            // zero trailing segment on the last item means it is absent
            if (d1 != 0 || !li)
                feed_segment(d1, 1'b0, 1'b0);
            if (used_cnt < COUNT_MAX)
                used_cnt++;
        end
        if (!li)
            return 1'b0;
        // final bit may finish without its second half
        if (status == mird_pkg::ST_RUNNING && second_half && rem == 0 &&
            done_cnt + 1 == bits_wanted())
            store_bit();
        ok = (status == mird_pkg::ST_DONE);
        rep.decoded_data = ok ? acc : '0;
        rep.frame_ok     = ok;
        rep.items_used   = ok ? ((used_cnt > 255) ? 8'd255 : used_cnt[7:0]) : '0;
        status = mird_pkg::ST_FAILED;
        return 1'b1;
    endfunction

    function automatic void apply_write(input logic [mird_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [mird_pkg::CFG_DATA_W-1:0] value);
        case (mird_pkg::cfg_index_t'(idx))
            mird_pkg::CFG_HALF_BIT_TIME:   half_q      = value[mird_pkg::HALF_W-1:0];
            mird_pkg::CFG_MATCH_TOLERANCE: tol_q       = value[mird_pkg::TOL_W-1:0];
            mird_pkg::CFG_MARK_IS_ZERO:    zero_mark_q = value[0];
            mird_pkg::CFG_HIGH_BIT_LEAD:   lead_q      = value[0];
            mird_pkg::CFG_FRAME_BITS:      nbits_q     = value[mird_pkg::NBITS_W-1:0];
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mird_pkg::result_t want;
        if (!rst_n)
        begin
            half_q      = mird_pkg::HALF_BIT_TIME_RST;
            tol_q       = mird_pkg::MATCH_TOLERANCE_RST;
            zero_mark_q = mird_pkg::MARK_IS_ZERO_RST;
            lead_q      = mird_pkg::HIGH_BIT_LEAD_RST;
            nbits_q     = mird_pkg::FRAME_BITS_RST;
            frame_clear();
            frame_reports_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results first: a report can never leave in the cycle its item arrives
            if (out_valid && out_ready)
            begin
                if (frame_reports_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, data %h ok %0b used %0d",
                             $time, decoded_data, frame_ok, items_used);
                    fail_count++;
                end
                else
                begin
                    want = frame_reports_q.pop_front();
                    if (decoded_data !== want.decoded_data)
                    begin
                        $display("%0t: decoded_data expected %h, got %h",
                                 $time, want.decoded_data, decoded_data);
                        fail_count++;
                    end
                    if (frame_ok !== want.frame_ok)
                    begin
                        $display("%0t: frame_ok expected %0b, got %0b",
                                 $time, want.frame_ok, frame_ok);
                        fail_count++;
                    end
                    if (items_used !== want.items_used)
                    begin
                        $display("%0t: items_used expected %0d, got %0d",
                                 $time, want.items_used, items_used);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                if (decode_item(first_duration, second_duration, start_level,
                                first_item, last_item, want))
                    frame_reports_q.insert(frame_reports_q.size(), want);
            end
            pending = frame_reports_q.size();
        end
    end

endmodule

>>> dv/manchester_ir_decoder_top_test.sv
`timescale 1ns / 1ps

module manchester_ir_decoder_top_test;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 6;

    // half bit, tolerance, polarity, order, frame length; a zero half bit means random
    localparam int SET_H   [PHASES] = '{889, 444, 1, 32767, 32767, 600, 1000, 16, 0};
    localparam int SET_TOL [PHASES] = '{200, 100, 0, 65535, 0, 299, 150, 7, 0};
    localparam int SET_POL [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 0};
    localparam int SET_MSB [PHASES] = '{1, 0, 0, 1, 1, 1, 0, 0, 0};
    localparam int SET_NB  [PHASES] = '{14, 20, 32, 1, 32, 0, 63, 40, 0};

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [mird_pkg::DUR_W-1:0]       first_duration;
    logic [mird_pkg::DUR_W-1:0]       second_duration;
    logic                             start_level;
    logic                             first_item;
    logic                             last_item;
    logic                             out_valid;
    logic                             out_ready;
    logic [mird_pkg::DATA_W-1:0]      decoded_data;
    logic                             frame_ok;
    logic [mird_pkg::USED_W-1:0]      items_used;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [mird_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mird_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                               fail_count;
    int                               pending;

    int cur_h;
    int cur_tol;
    bit cur_pol;
    bit cur_msb;
    int cur_nbits;
    bit in_gaps_on;
    bit out_stalls_on;
    bit hold_req;

    manchester_ir_decoder_top dut (.*);

    mird_frame_checker frame_check (.*);

    always #5 clk = ~clk;

    task automatic push_item(input logic [mird_pkg::DUR_W-1:0] d0,
                             input logic [mird_pkg::DUR_W-1:0] d1,
                             input logic sl, input logic fi, input logic li);
        int gap;
        gap = in_gaps_on ? int'($urandom_range(0, 6)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        first_duration  <= d0;
        second_duration <= d1;
        start_level     <= sl;
        first_item      <= fi;
        last_item       <= li;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // sender stops and waits for every outstanding report, then lets the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input mird_pkg::cfg_index_t idx,
                             input logic [mird_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input int h, input int tol, input bit pol, input bit msb,
                                 input int nb);
        wait_idle();
        write_reg(mird_pkg::CFG_HALF_BIT_TIME, 16'(h));
        write_reg(mird_pkg::CFG_MATCH_TOLERANCE, 16'(tol));
        write_reg(mird_pkg::CFG_MARK_IS_ZERO, 16'(pol));
        write_reg(mird_pkg::CFG_HIGH_BIT_LEAD, 16'(msb));
        write_reg(mird_pkg::CFG_FRAME_BITS, 16'(nb));
        cfg_valid <= 1'b0;
        cur_h     = h;
        cur_tol   = tol;
        cur_pol   = pol;
        cur_msb   = msb;
        cur_nbits = nb;
    endtask

    // Manchester-encodes a word, merges equal halves into runs and sends them in pairs
    task automatic send_frame(input logic [31:0] word, input int nbits, input int jit,
                              input bit drop_tail, input bit with_first, input int extra,
                              output int n_items);
        bit halves[$];
        int runs[$];
        int durs[$];
        int i;
        int k;
        int pos;
        int d;
        bit v;
        bit l1;
        bit lvl0;
        bit closing;
        for (i = 0; i < nbits; i++)
        begin
            pos = cur_msb ? nbits - 1 - i : i;
            v   = word[pos];
            l1  = cur_pol ? ~v : v;
            halves.insert(halves.size(), l1);
            halves.insert(halves.size(), ~l1);
        end
        lvl0 = halves[0];
        runs.insert(runs.size(), 1);
        for (i = 1; i < halves.size(); i++)
        begin
            if (halves[i] == halves[i-1])
                runs[$] = runs[$] + 1;
            else
                runs.insert(runs.size(), 1);
        end
        // the last run is always the lone second half of the final bit
        if (drop_tail)
            void'(runs.pop_back());
        foreach (runs[j])
        begin
            d = runs[j] * cur_h + int'($urandom_range(0, 2 * jit)) - jit;
            if (d < 0)
                d = 0;
            if (d > 65535)
                d = 65535;
            durs.insert(durs.size(), d);
        end
        k = 0;
        n_items = 0;
        while (k < durs.size())
        begin
            closing = (extra == 0) && (k + 2 >= durs.size());
            push_item(16'(durs[k]), (k + 1 < durs.size()) ? 16'(durs[k+1]) : 16'd0,
                      (k == 0) ? lvl0 : 1'($urandom), with_first && k == 0, closing);
            n_items++;
            k += 2;
        end
        for (i = 0; i < extra; i++)
            push_item(16'($urandom), 16'($urandom), 1'($urandom), 1'b0, i == extra - 1);
    endtask

    task automatic random_frame(output int n_items);
        int pick;
        int nb;
        int jmax;
        int jit;
        int cnt;
        int dummy;
        logic [31:0] word;
        pick = $urandom_range(0, 99);
        word = $urandom;
        if (cur_nbits == 0)
            nb = $urandom_range(1, 32);
        else
            nb = (cur_nbits > mird_pkg::MAX_BITS_DEF) ? mird_pkg::MAX_BITS_DEF : cur_nbits;
        jmax = ((cur_h - 1) / 2 < cur_tol) ? (cur_h - 1) / 2 : cur_tol;
        jit  = $urandom_range(0, jmax);
        n_items = 0;
        if (pick < 60)
            send_frame(word, nb, jit, 1'($urandom), 1'b1, 0, n_items);
        else if (pick < 68)
            send_frame(word, nb, jit, 1'b0, 1'b1, $urandom_range(1, 3), n_items);
        else if (pick < 76)
        begin
            // bit count off by a few
            if ($urandom_range(0, 1))
                nb = nb + int'($urandom_range(1, 3));
            else
                nb = nb - int'($urandom_range(1, 3));
            if (nb < 1)
                nb = 1;
            if (nb > 32)
                nb = 32;
            send_frame(word, nb, jit, 1'($urandom), 1'b1, 0, n_items);
        end
        else if (pick < 84)
            send_frame(word, nb, jmax + 1 + int'($urandom_range(0, cur_h)), 1'($urandom),
                       1'b1, 0, n_items);
        else if (pick < 90)
            // no frame start: mostly lands on a closed frame
            send_frame(word, nb, jit, 1'($urandom), 1'b0, 0, dummy);
        else
        begin
            cnt = $urandom_range(1, 4);
            repeat (cnt)
                push_item(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            n_items = cnt;
        end
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin
        int stall;
        bit held;
        out_ready = 1'b0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else
                stall = out_stalls_on ? int'($urandom_range(0, 6)) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        #(5_000_000);
        $display("manchester_ir_decoder_top_test failed");
        $finish;
    end

    initial
    begin
        int p;
        int sent;
        int n;
        int dummy;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        first_duration  = '0;
        second_duration = '0;
        start_level     = 1'b0;
        first_item      = 1'b0;
        last_item       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_gaps_on      = 1'b1;
        out_stalls_on   = 1'b1;
        hold_req        = 1'b0;
        cur_h           = mird_pkg::HALF_BIT_TIME_RST;
        cur_tol         = mird_pkg::MATCH_TOLERANCE_RST;
        cur_pol         = mird_pkg::MARK_IS_ZERO_RST;
        cur_msb         = mird_pkg::HIGH_BIT_LEAD_RST;
        cur_nbits       = mird_pkg::FRAME_BITS_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings
        // no frame start: continues the frame opened by reset
        push_item(16'd889, 16'd1778, 1'b0, 1'b0, 1'b0);
        push_item(16'd889, 16'd0, 1'b1, 1'b0, 1'b1);
        // frame closed: ignored, then the last mark reports a failure
        push_item(16'd889, 16'd889, 1'b0, 1'b0, 1'b0);
        push_item(16'd889, 16'd889, 1'b1, 1'b0, 1'b1);
        push_item(16'd0, 16'd65535, 1'b1, 1'b1, 1'b1);
        push_item(16'd65535, 16'd0, 1'b0, 1'b1, 1'b1);
        // zero segment mid-frame
        push_item(16'd889, 16'd0, 1'b1, 1'b1, 1'b0);
        push_item(16'd889, 16'd889, 1'b0, 1'b0, 1'b1);
        // missing final segment
        send_frame(32'h0000_2A5C, 14, 150, 1'b1, 1'b1, 0, dummy);
        // extra items after the last bit
        send_frame(32'h0000_1337, 14, 0, 1'b0, 1'b1, 2, dummy);

        for (p = 0; p < PHASES; p++)
        begin
            if (SET_H[p] == 0)
            begin
                n = $urandom_range(2, 5000);
                apply_setting(n, $urandom_range(0, n), 1'($urandom), 1'($urandom),
                              $urandom_range(1, 32));
            end
            else
                apply_setting(SET_H[p], SET_TOL[p], SET_POL[p], SET_MSB[p], SET_NB[p]);
            if (p == 1)
                hold_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                in_gaps_on    = ($urandom_range(0, 3) != 0);
                out_stalls_on = ($urandom_range(0, 3) != 0);
                random_frame(n);
                sent += n;
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("manchester_ir_decoder_top_test passed");
        else
            $display("manchester_ir_decoder_top_test failed");
        $finish;
    end

endmodule

>>> filelist.f
design/mird_pkg.sv
design/mird_cfg_regs.sv
design/mird_frame_core.sv
design/manchester_ir_decoder_top.sv
dv/mird_frame_checker.sv
dv/manchester_ir_decoder_top_test.sv
